FILE: rtl/gpck_pkg.sv
// Package for the knight-guarded lattice path counter.
// Holds field widths and the control struct passed to the cell unit.
// No dependencies.
`timescale 1ns / 1ps

package gpck_pkg;

  localparam int COORD_W = 6;
  localparam int COUNT_W = 62;
  localparam int PATH_W  = 63;

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic bypass;
  } cell_ctl_t;

endpackage

FILE: rtl/gpck_if.sv
// Valid/ready channel interfaces for query and result transactions.
// Depends on gpck_pkg.
`timescale 1ns / 1ps

interface gpck_in_if import gpck_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] target_row;
  logic [COORD_W-1:0] target_col;
  logic [COORD_W-1:0] guard_row;
  logic [COORD_W-1:0] guard_col;

  modport source (output valid, target_row, target_col, guard_row, guard_col, input ready);
  modport sink   (input valid, target_row, target_col, guard_row, guard_col, output ready);
endinterface

interface gpck_out_if import gpck_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PATH_W-1:0] path_count;

  modport source (output valid, path_count, input ready);
  modport sink   (input valid, path_count, output ready);
endinterface

FILE: rtl/gpck_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gpck_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/gpck_cell_unit.sv
// Shared cell unit: guard/knight block test and the one count adder.
// Keeps the last computed cell value. Depends on gpck_pkg.
`timescale 1ns / 1ps

module gpck_cell_unit import gpck_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  cell_ctl_t          ctl_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic [COORD_W-1:0] guard_row_i,
  input  logic [COORD_W-1:0] guard_col_i,
  input  logic [COUNT_W-1:0] up_rd_i,
  output logic [COUNT_W-1:0] value_o,
  output logic [COUNT_W-1:0] last_q_o
);

  logic signed [COORD_W:0] dr;
  logic signed [COORD_W:0] dc;
  logic                    dr1, dr2, dc1, dc2;
  logic                    blocked;
  logic [COUNT_W-1:0]      up;
  logic [COUNT_W-1:0]      left;
  logic [COUNT_W-1:0]      last_q;

  assign dr = $signed({1'b0, row_i}) - $signed({1'b0, guard_row_i});
  assign dc = $signed({1'b0, col_i}) - $signed({1'b0, guard_col_i});

  assign dr1 = (dr == 7'sd1) || (dr == -7'sd1);
  assign dr2 = (dr == 7'sd2) || (dr == -7'sd2);
  assign dc1 = (dc == 7'sd1) || (dc == -7'sd1);
  assign dc2 = (dc == 7'sd2) || (dc == -7'sd2);

  assign blocked = ((dr == '0) && (dc == '0)) || (dr1 && dc2) || (dr2 && dc1);

  // up comes from the row store, or from the previous cell on a one-column grid
  assign up   = ctl_i.first_row ? '0 : (ctl_i.bypass ? last_q : up_rd_i);
  assign left = ctl_i.first_col ? '0 : last_q;

  always_comb begin
    if (blocked) begin
      value_o = '0;
    end else if (ctl_i.first_row && ctl_i.first_col) begin
      value_o = COUNT_W'(1);
    end else begin
      value_o = up + left;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last_q <= value_o;
    end
  end

  assign last_q_o = last_q;

endmodule

FILE: rtl/grid_path_count_knight_block.sv
// Top level: lattice path counter with a knight-guarded obstacle.
// Sequencer, row store and shared cell unit. Depends on gpck_pkg, gpck_if,
// gpck_ram, gpck_cell_unit.
//
//   port    dir  fields                                        handshake
//   in_i    in   target_row, target_col, guard_row, guard_col  valid/ready
//   out_o   out  path_count                                    valid/ready
//
// A query visits (n+1)*(m+1) cells, one per cycle, through one adder and one
// read/write port pair of the row store; n, m are the targets saturated to
// MAX_COORD. in_i.ready returns in the cycle the result becomes valid.
// No clearing pass after reset. in_i.ready is low while a query runs; a run
// that ends while the previous result still sits in the output register
// waits in ST_DONE until that result is taken.
`timescale 1ns / 1ps

module grid_path_count_knight_block import gpck_pkg::*; #(
  parameter int MAX_COORD = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gpck_in_if.sink    in_i,
  gpck_out_if.source out_o
);

  localparam int Depth = MAX_COORD + 1;
  localparam int CW    = $clog2(Depth);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CW-1:0]      tn_q, tn_d, tm_q, tm_d;
  logic [COORD_W-1:0] gr_q, gr_d, gc_q, gc_d;
  logic [CW-1:0]      ri_q, ri_d, ci_q, ci_d;
  logic               issue_done_q, issue_done_d;
  logic               b_valid_q, b_valid_d;
  logic [CW-1:0]      bi_q, bi_d, bj_q, bj_d;
  logic               byp_q, byp_d;
  logic [PATH_W-1:0]  path_count_q, path_count_d;
  logic               out_valid_q, out_valid_d;

  logic               rd_en;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] cell_value;
  logic [COUNT_W-1:0] last_value;
  cell_ctl_t          cell_ctl;
  logic               in_fire;
  logic               out_free;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.path_count = path_count_q;

  assign rd_en = (state_q == ST_RUN) && !issue_done_q;

  assign cell_ctl.first_row = (bi_q == '0);
  assign cell_ctl.first_col = (bj_q == '0);
  assign cell_ctl.bypass    = byp_q;

  always_comb begin
    state_d      = state_q;
    tn_d         = tn_q;
    tm_d         = tm_q;
    gr_d         = gr_q;
    gc_d         = gc_q;
    ri_d         = ri_q;
    ci_d         = ci_q;
    issue_done_d = issue_done_q;
    b_valid_d    = b_valid_q;
    bi_d         = bi_q;
    bj_d         = bj_q;
    byp_d        = byp_q;
    path_count_d = path_count_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          tn_d = (in_i.target_row > COORD_W'(MAX_COORD)) ? CW'(MAX_COORD)
                                                         : in_i.target_row[CW-1:0];
          tm_d = (in_i.target_col > COORD_W'(MAX_COORD)) ? CW'(MAX_COORD)
                                                         : in_i.target_col[CW-1:0];
          gr_d         = in_i.guard_row;
          gc_d         = in_i.guard_col;
          ri_d         = '0;
          ci_d         = '0;
          issue_done_d = 1'b0;
          b_valid_d    = 1'b0;
          byp_d        = 1'b0;
          state_d      = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!issue_done_q) begin
          b_valid_d = 1'b1;
          bi_d      = ri_q;
          bj_d      = ci_q;
          // read of the column being written this cycle returns stale data
          byp_d     = b_valid_q && (bj_q == ci_q);
          if (ci_q == tm_q) begin
            ci_d = '0;
            if (ri_q == tn_q) begin
              issue_done_d = 1'b1;
            end else begin
              ri_d = ri_q + CW'(1);
            end
          end else begin
            ci_d = ci_q + CW'(1);
          end
        end else begin
          b_valid_d = 1'b0;
          byp_d     = 1'b0;
          if (out_free) begin
            path_count_d = PATH_W'(cell_value);
            out_valid_d  = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // final cell value is held in the cell unit
        if (out_free) begin
          path_count_d = PATH_W'(last_value);
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ri_q         <= '0;
      ci_q         <= '0;
      issue_done_q <= 1'b0;
      b_valid_q    <= 1'b0;
      byp_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      ri_q         <= ri_d;
      ci_q         <= ci_d;
      issue_done_q <= issue_done_d;
      b_valid_q    <= b_valid_d;
      byp_q        <= byp_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tn_q         <= tn_d;
    tm_q         <= tm_d;
    gr_q         <= gr_d;
    gc_q         <= gc_d;
    bi_q         <= bi_d;
    bj_q         <= bj_d;
    path_count_q <= path_count_d;
  end

  gpck_ram #(
    .Width (COUNT_W),
    .Depth (Depth)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (bj_q),
    .wdata_i (cell_value),
    .re_i    (rd_en),
    .raddr_i (ci_q),
    .rdata_o (rd_data)
  );

  gpck_cell_unit u_cell (
    .clk_i       (clk_i),
    .en_i        (b_valid_q),
    .ctl_i       (cell_ctl),
    .row_i       (COORD_W'(bi_q)),
    .col_i       (COORD_W'(bj_q)),
    .guard_row_i (gr_q),
    .guard_col_i (gc_q),
    .up_rd_i     (rd_data),
    .value_o     (cell_value),
    .last_q_o    (last_value)
  );

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid && $stable(out_o.path_count))
    else $error("pending result dropped or changed");

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_RUN) && !issue_done_q && !b_valid_q)
    else $error("query accept did not start a run");

  a_bypass_single_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byp_q |-> (tm_q == '0)) else $error("store bypass outside one-column grid");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (ci_q <= tm_q) && (ri_q <= tn_q))
    else $error("issue pointer beyond target");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && issue_done_q) |=> (state_q != ST_RUN) && out_o.valid)
    else $error("run did not finish after last cell");

endmodule
